>>> sv/xasf_pkg.sv
// ----------------------------------------------------------------------------
// xasf_pkg
// Types, codes and helpers shared by the ALU status flag pipeline.
// ----------------------------------------------------------------------------
package xasf_pkg;

    localparam int unsigned DATA_W = 64;

    // Raw mode codes as they arrive on the input port
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_XOR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } t_size;

    // Stage 1 -> stage 2
    typedef struct packed {
        t_op                op;
        t_size              size;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic               a_top;
        logic               b_top;
    } t_dec;

    // Stage 2 -> stage 3
    typedef struct packed {
        t_op                op;
        t_size              size;
        logic [DATA_W:0]    raw;
        logic               a_top;
        logic               b_top;
    } t_alu;

    function automatic logic [DATA_W-1:0] width_mask(input t_size size);
        logic [DATA_W-1:0] m;
        case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00ff;
            SIZE_16: m = 64'h0000_0000_0000_ffff;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            SIZE_64: m = '1;
            default: m = '1;
        endcase
        return m;
    endfunction

    // Sign bit of a value at the selected width
    function automatic logic top_bit(input t_size size, input logic [DATA_W-1:0] v);
        logic t;
        case (size)
            SIZE_8:  t = v[7];
            SIZE_16: t = v[15];
            SIZE_32: t = v[31];
            SIZE_64: t = v[63];
            default: t = v[63];
        endcase
        return t;
    endfunction

endpackage

>>> sv/x86_alu_status_flags.sv
// ----------------------------------------------------------------------------
// x86_alu_status_flags
// Add, subtract/compare and xor at 8/16/32/64 bits with x86 CF, ZF, SF,
// OF and PF flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid with i_mode, i_size_sel, i_operand_a and
//   i_operand_b; a request is taken at a clock edge with i_valid high and
//   o_stall low. Output channel: o_valid with o_result and the five flags;
//   a result is taken at an edge with o_valid high and i_stall low.
//   Three register stages: operand decode and masking, one 65-bit
//   add, subtract or xor, then truncation and flag forming. A request
//   passes the decode, arith and flags registers in that order before
//   it is offered on the output.
//   Throughput is one request per cycle while i_stall stays low; the
//   65-bit adder in the middle stage sets the clock.
//   i_stall holds the output register; empty stages upstream still fill,
//   so o_stall rises only once all three stages hold requests.
//   Reset (i_rst_n low at a clock edge) empties every stage.
// ----------------------------------------------------------------------------
module x86_alu_status_flags
    import xasf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_size_sel,
    input  logic [DATA_W-1:0]   i_operand_a,
    input  logic [DATA_W-1:0]   i_operand_b,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DATA_W-1:0]   o_result,
    output logic                o_carry_flag,
    output logic                o_zero_flag,
    output logic                o_sign_flag,
    output logic                o_overflow_flag,
    output logic                o_parity_flag
);

    logic   dec_ready;
    logic   dec_valid;
    t_dec   dec_data;
    logic   alu_ready;
    logic   alu_valid;
    t_alu   alu_data;
    logic   flg_ready;

    xasf_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_size_sel   (i_size_sel),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_ready_next (alu_ready),
        .o_ready      (dec_ready),
        .o_valid      (dec_valid),
        .o_dec        (dec_data)
    );

    xasf_arith u_arith (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dec_valid),
        .i_dec        (dec_data),
        .i_ready_next (flg_ready),
        .o_ready      (alu_ready),
        .o_valid      (alu_valid),
        .o_alu        (alu_data)
    );

    xasf_flags u_flags (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (alu_valid),
        .i_alu           (alu_data),
        .i_stall         (i_stall),
        .o_ready         (flg_ready),
        .o_valid         (o_valid),
        .o_result        (o_result),
        .o_carry_flag    (o_carry_flag),
        .o_zero_flag     (o_zero_flag),
        .o_sign_flag     (o_sign_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_parity_flag   (o_parity_flag)
    );

    assign o_stall = !dec_ready;

endmodule

>>> sv/xasf_decode.sv
// ----------------------------------------------------------------------------
// xasf_decode
// Stage 1: decodes the operation and masks both operands to the width.
// ----------------------------------------------------------------------------
module xasf_decode
    import xasf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_size_sel,
    input  logic [DATA_W-1:0]   i_operand_a,
    input  logic [DATA_W-1:0]   i_operand_b,
    input  logic                i_ready_next,
    output logic                o_ready,
    output logic                o_valid,
    output t_dec                o_dec
);

    logic               r_valid;
    t_dec               r_dec;
    t_dec               n_dec;
    t_size              size;
    logic [DATA_W-1:0]  mask;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        size = t_size'(i_size_sel);
        mask = width_mask(size);
        // mode 3 falls in with xor: only the top bit picks logic ops
        if (i_mode[1]) begin
            n_dec.op = OP_XOR;
        end else if (i_mode == MODE_SUB) begin
            n_dec.op = OP_SUB;
        end else begin
            n_dec.op = OP_ADD;
        end
        n_dec.size  = size;
        n_dec.a     = i_operand_a & mask;
        n_dec.b     = i_operand_b & mask;
        n_dec.a_top = top_bit(size, i_operand_a);
        n_dec.b_top = top_bit(size, i_operand_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

>>> sv/xasf_arith.sv
// ----------------------------------------------------------------------------
// xasf_arith
// Stage 2: one 65-bit add, subtract or xor on the masked operands.
// ----------------------------------------------------------------------------
module xasf_arith
    import xasf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dec    i_dec,
    input  logic    i_ready_next,
    output logic    o_ready,
    output logic    o_valid,
    output t_alu    o_alu
);

    logic   r_valid;
    t_alu   r_alu;
    t_alu   n_alu;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        n_alu.op    = i_dec.op;
        n_alu.size  = i_dec.size;
        n_alu.a_top = i_dec.a_top;
        n_alu.b_top = i_dec.b_top;
        // operands are masked, so bit 64 of a difference is the borrow
        case (i_dec.op)
            OP_ADD:  n_alu.raw = {1'b0, i_dec.a} + {1'b0, i_dec.b};
            OP_SUB:  n_alu.raw = {1'b0, i_dec.a} - {1'b0, i_dec.b};
            OP_XOR:  n_alu.raw = {1'b0, i_dec.a ^ i_dec.b};
            default: n_alu.raw = {1'b0, i_dec.a ^ i_dec.b};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_alu <= n_alu;
        end
    end

    assign o_valid = r_valid;
    assign o_alu   = r_alu;

endmodule

>>> sv/xasf_flags.sv
// ----------------------------------------------------------------------------
// xasf_flags
// Stage 3: truncates the result and forms CF, ZF, SF, OF and PF.
// Its registers drive the output channel.
// ----------------------------------------------------------------------------
module xasf_flags
    import xasf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_alu                i_alu,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_result,
    output logic                o_carry_flag,
    output logic                o_zero_flag,
    output logic                o_sign_flag,
    output logic                o_overflow_flag,
    output logic                o_parity_flag
);

    logic               r_valid;
    logic [DATA_W-1:0]  r_result;
    logic               r_cf;
    logic               r_zf;
    logic               r_sf;
    logic               r_of;
    logic               r_pf;
    logic [DATA_W-1:0]  n_result;
    logic               n_cf;
    logic               n_sf;
    logic               n_of;
    logic               carry_out;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_result = i_alu.raw[DATA_W-1:0] & width_mask(i_alu.size);
        n_sf     = top_bit(i_alu.size, n_result);
        case (i_alu.size)
            SIZE_8:  carry_out = i_alu.raw[8];
            SIZE_16: carry_out = i_alu.raw[16];
            SIZE_32: carry_out = i_alu.raw[32];
            SIZE_64: carry_out = i_alu.raw[64];
            default: carry_out = i_alu.raw[64];
        endcase
        case (i_alu.op)
            OP_ADD: begin
                n_cf = carry_out;
                n_of = (i_alu.a_top == i_alu.b_top) && (n_sf != i_alu.a_top);
            end
            OP_SUB: begin
                n_cf = i_alu.raw[DATA_W];
                n_of = (i_alu.a_top != i_alu.b_top) && (n_sf != i_alu.a_top);
            end
            default: begin
                n_cf = 1'b0;
                n_of = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
            r_cf     <= n_cf;
            r_zf     <= (n_result == '0);
            r_sf     <= n_sf;
            r_of     <= n_of;
            r_pf     <= ~^n_result[7:0];
        end
    end

    assign o_valid         = r_valid;
    assign o_result        = r_result;
    assign o_carry_flag    = r_cf;
    assign o_zero_flag     = r_zf;
    assign o_sign_flag     = r_sf;
    assign o_overflow_flag = r_of;
    assign o_parity_flag   = r_pf;

`ifndef SYNTHESIS
    a_xor_clears_cf_of: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_alu.op == OP_XOR) |=> (!r_cf && !r_of))
        else $error("xor request left carry or overflow set");

    a_byte_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_alu.size == SIZE_8) |=> (r_result[63:8] == '0))
        else $error("8-bit result has upper bits set");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid)
        else $error("stalled result dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("output stage valid after reset");
`endif

endmodule

>>> tb/sv/x86_alu_status_flags_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_alu_status_flags_tb
// Self-checking bench for the ALU status flag pipeline: directed corner
// requests, then random add/sub/xor traffic under several idle and stall
// mixes. Every result is checked field by field against a local model.
// ----------------------------------------------------------------------------
import xasf_pkg::*;

typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              carry;
    logic              zero;
    logic              sign;
    logic              ovf;
    logic              parity;
} t_flags_word;

function automatic logic [DATA_W-1:0] size_ones(input logic [1:0] size_sel);
    logic [DATA_W-1:0] m;
    case (t_size'(size_sel))
        SIZE_8:  m = 64'h0000_0000_0000_00ff;
        SIZE_16: m = 64'h0000_0000_0000_ffff;
        SIZE_32: m = 64'h0000_0000_ffff_ffff;
        default: m = {DATA_W{1'b1}};
    endcase
    return m;
endfunction

function automatic t_flags_word predict_flags(input logic [1:0] mode,
                                              input logic [1:0] size_sel,
                                              input logic [DATA_W-1:0] a_in,
                                              input logic [DATA_W-1:0] b_in);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] ov_bits;
    int                msb;
    t_flags_word       x;
    m = size_ones(size_sel);
    case (t_size'(size_sel))
        SIZE_8:  msb = 7;
        SIZE_16: msb = 15;
        SIZE_32: msb = 31;
        default: msb = 63;
    endcase
    a = a_in & m;
    b = b_in & m;
    x.carry = 1'b0;
    x.ovf   = 1'b0;
    if (mode == MODE_ADD) begin
        r       = (a + b) & m;
        x.carry = (r < a);
        ov_bits = (a ^ r) & (b ^ r);
        x.ovf   = ov_bits[msb];
    end else if (mode == MODE_SUB) begin
        r       = (a - b) & m;
        x.carry = (b > a);
        ov_bits = (a ^ b) & (a ^ r);
        x.ovf   = ov_bits[msb];
    end else begin
        // top mode bit set: exclusive or, including the unused code
        r = (a ^ b) & m;
    end
    x.result = r;
    x.zero   = (r == '0);
    x.sign   = r[msb];
    x.parity = ~(^r[7:0]);
    return x;
endfunction

class flags_scoreboard;
    t_flags_word expected_q[$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new();
        n_errors  = 0;
        n_checked = 0;
    endfunction

    task report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        n_errors++;
    endtask

    function void note_request(input logic [1:0] mode, input logic [1:0] size_sel,
                               input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        expected_q.push_back(predict_flags(mode, size_sel, a, b));
    endfunction

    task check_result(input t_flags_word got);
        t_flags_word want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %h with no request pending", got.result));
            return;
        end
        want = expected_q.pop_front();
        n_checked++;
        if (got.result !== want.result)
            report_mismatch($sformatf("result got %h want %h", got.result, want.result));
        if (got.carry !== want.carry)
            report_mismatch($sformatf("CF got %b want %b (result %h)",
                                      got.carry, want.carry, want.result));
        if (got.zero !== want.zero)
            report_mismatch($sformatf("ZF got %b want %b (result %h)",
                                      got.zero, want.zero, want.result));
        if (got.sign !== want.sign)
            report_mismatch($sformatf("SF got %b want %b (result %h)",
                                      got.sign, want.sign, want.result));
        if (got.ovf !== want.ovf)
            report_mismatch($sformatf("OF got %b want %b (result %h)",
                                      got.ovf, want.ovf, want.result));
        if (got.parity !== want.parity)
            report_mismatch($sformatf("PF got %b want %b (result %h)",
                                      got.parity, want.parity, want.result));
    endtask
endclass

module x86_alu_status_flags_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_mode = MODE_ADD;
    logic [1:0]        i_size_sel = SIZE_8;
    logic [DATA_W-1:0] i_operand_a = '0;
    logic [DATA_W-1:0] i_operand_b = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [DATA_W-1:0] o_result;
    logic              o_carry_flag;
    logic              o_zero_flag;
    logic              o_sign_flag;
    logic              o_overflow_flag;
    logic              o_parity_flag;

    flags_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_request  = 1'b0;
    int unsigned n_holds       = 0;
    int unsigned mode_hits[4]  = '{default: 0};
    int unsigned size_hits[4]  = '{default: 0};

    x86_alu_status_flags dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_size_sel      (i_size_sel),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result        (o_result),
        .o_carry_flag    (o_carry_flag),
        .o_zero_flag     (o_zero_flag),
        .o_sign_flag     (o_sign_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_parity_flag   (o_parity_flag)
    );

    always #5 i_clk = ~i_clk;

    // Both monitors sample pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_request(i_mode, i_size_sel, i_operand_a, i_operand_b);
            mode_hits[i_mode]++;
            size_hits[i_size_sel]++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_result, o_carry_flag, o_zero_flag, o_sign_flag,
                              o_overflow_flag, o_parity_flag});
    end

    // Output side: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                n_holds++;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Holds the payload until the request is taken
    task send_request(input logic [1:0] mode, input logic [1:0] size_sel,
                      input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_size_sel  <= size_sel;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand(input logic [1:0] size_sel);
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] v;
        int unsigned       kind;
        m    = size_ones(size_sel);
        junk = {$urandom, $urandom};
        kind = $urandom_range(9);
        case (kind)
            0:       v = '0;
            1:       v = m;
            2:       v = m >> 1;
            3:       v = ~(m >> 1) & m;
            4:       v = 64'd1;
            default: v = junk;
        endcase
        if (kind <= 4 && $urandom_range(1) == 1)
            v = (junk & ~m) | v;
        return v;
    endfunction

    task random_request();
        logic [1:0]        mode;
        logic [1:0]        size_sel;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int unsigned       pick;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        pick = $urandom_range(15);
        if (pick < 5)
            mode = MODE_ADD;
        else if (pick < 10)
            mode = MODE_SUB;
        else if (pick < 15)
            mode = OP_XOR;
        else
            mode = MODE_UNUSED;
        size_sel = 2'($urandom_range(3));
        a = pick_operand(size_sel);
        b = pick_operand(size_sel);
        if ($urandom_range(9) == 0)
            b = a;
        send_request(mode, size_sel, a, b);
    endtask

    task wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] junk;
        int unsigned       ph;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at each width, garbage above the width
        for (int s = 0; s < 4; s++) begin
            m    = size_ones(2'(s));
            junk = {$urandom, $urandom} & ~m;
            send_request(MODE_ADD, 2'(s), m | junk, 64'd1 | ~m);   // wrap to zero
            send_request(MODE_ADD, 2'(s), m >> 1, 64'd1);          // signed overflow
            send_request(MODE_SUB, 2'(s), junk, 64'd1);            // borrow
            send_request(MODE_SUB, 2'(s), ~(m >> 1) & m, 64'd1);  // min - 1
            send_request((s % 2 == 0) ? OP_XOR : MODE_UNUSED, 2'(s), m, m | junk);
        end
        wait_for_drain();

        // Long output hold-off with the sender pushing until it backs up
        hold_request = 1'b1;
        repeat (30) random_request();
        wait_for_drain();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 49; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (230) random_request();
            wait_for_drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("Checked %0d results, %0d holds; modes add/sub/xor/unused %0d/%0d/%0d/%0d",
                 sb.n_checked, n_holds, mode_hits[0], mode_hits[1], mode_hits[2],
                 mode_hits[3]);
        $display("Widths 8/16/32/64: %0d/%0d/%0d/%0d; mismatches %0d",
                 size_hits[0], size_hits[1], size_hits[2], size_hits[3], sb.n_errors);
        if (sb.n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for the pipeline");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/xasf_pkg.sv
sv/xasf_decode.sv
sv/xasf_arith.sv
sv/xasf_flags.sv
sv/x86_alu_status_flags.sv
tb/sv/x86_alu_status_flags_tb.sv
